>>> rtl/core/adrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_pkg: shared types and codes for the ADRC rate controller
// Register indexes, datapath opcodes, operand selects and controller states.
// ----------------------------------------------------------------------------
package adrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD  = 3'd0,
        REG_CTRL_BANDWIDTH = 3'd1,
        REG_OBS_BANDWIDTH  = 3'd2,
        REG_GAIN_REFERENCE = 3'd3,
        REG_PRESSURE_GAIN  = 3'd4,
        REG_SCALE_MIN      = 3'd5,
        REG_SCALE_MAX      = 3'd6
    } reg_idx_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,      // dst = mulq(a, b)
        OP_ADD,      // dst = sat(a + b)
        OP_SUB,      // dst = sat(a - b)
        OP_NEG,      // dst = sat(-a)
        OP_TRIPLE,   // dst = sat(3a)
        OP_DOUBLE,   // dst = sat(2a)
        OP_DIV,      // start divider: T3 = divq(a, b0)
        OP_SCHED,    // s clamp against scale limits
        OP_B0LIM,    // b0 limit to [1, 2^31-1]
        OP_VFLOOR,   // airspeed floor at one
        OP_COMMIT    // write observer state, z3 clamp
    } op_t;

    // operand / destination slots in the scratch file
    typedef enum logic [3:0] {
        SL_R, SL_Y, SL_V, SL_DT, SL_WC, SL_WO, SL_PG, SL_GR,
        SL_Z1, SL_Z2, SL_Z3, SL_T0, SL_T1, SL_T2, SL_T3, SL_B0
    } slot_t;

    typedef struct packed {
        op_t   op;
        slot_t a;
        slot_t b;
        slot_t dst;
    } cmd_t;

    typedef struct packed {
        logic busy;   // multi-cycle unit still working
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT
    } state_t;

    localparam int NUM_STEPS = 33;

endpackage

>>> rtl/core/adrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_datapath: scratch registers, shared multiplier and serial divider
// Executes one command per cycle; the serial divider flags busy while it works.
// ----------------------------------------------------------------------------
module adrc_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic [31:0]           in_r,
    input  logic [31:0]           in_y,
    input  logic [24:0]           in_v,
    input  logic [16:0]           cfg_dt,
    input  logic [22:0]           cfg_wc,
    input  logic [22:0]           cfg_wo,
    input  logic [24:0]           cfg_gr,
    input  logic [16:0]           cfg_pg,
    input  logic [22:0]           cfg_smin,
    input  logic [22:0]           cfg_smax,
    input  adrc_pkg::cmd_t        cmd,
    output adrc_pkg::stat_t       stat,
    output logic [17:0]           drive,
    output logic [22:0]           dist_est,
    output logic [30:0]           gain
);
    import adrc_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [W-1:0] ZLIM = W'(64'sd50 <<< FRAC_BITS);
    localparam int QW = W + FRAC_BITS;       // quotient bits before sat
    localparam int CW = $clog2(QW + 1);

    logic signed [W-1:0] rf_reg [16];
    logic signed [W-1:0] z1_reg, z2_reg, z3_reg;
    logic signed [W-1:0] opa, opb, res;
    logic                wr;

    // saturate a wide signed value into W bits
    function automatic logic signed [W-1:0] satw(input logic signed [W+1:0] x);
        if (x > (W+2)'(VMAX))      satw = VMAX;
        else if (x < (W+2)'(VMIN)) satw = VMIN;
        else                       satw = x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sext(input logic [31:0] x);
        logic signed [47:0] t;
        t = 48'(signed'(x));
        if (t > 48'(VMAX))      sext = VMAX;
        else if (t < 48'(VMIN)) sext = VMIN;
        else                    sext = t[W-1:0];
    endfunction

    assign opa = rf_reg[cmd.a];
    assign opb = rf_reg[cmd.b];

    // multiplier: sign-magnitude, shift, truncate toward zero, saturate
    logic [W-1:0]  ma, mb;
    logic [PW-1:0] mp, ms;
    logic          mneg;
    logic signed [W-1:0] mres;
    always_comb begin
        ma   = opa[W-1] ? W'(-opa) : opa;
        mb   = opb[W-1] ? W'(-opb) : opb;
        mp   = PW'(ma) * PW'(mb);
        ms   = mp >> FRAC_BITS;
        mneg = opa[W-1] ^ opb[W-1];
        if (mneg) begin
            if (ms > PW'(VMAX) + PW'(1)) mres = VMIN;
            else                        mres = W'(-ms);
        end else begin
            if (ms > PW'(VMAX)) mres = VMAX;
            else               mres = ms[W-1:0];
        end
    end

    // serial restoring divider: (|num| << FRAC_BITS) / b0, one bit a cycle
    logic [QW-1:0] dq_reg, dq_next;
    logic [W:0]    drm_reg, drm_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic          dneg_reg, dneg_next, dbusy_reg, dbusy_next;
    logic          ddone;
    logic [W+1:0]  dtry;
    logic [W-1:0]  b0mag;
    logic signed [W-1:0] dres;
    localparam logic [QW-1:0] QLIM = QW'(VMAX) + QW'(1);

    assign b0mag = rf_reg[SL_B0];
    assign dtry  = {drm_reg, dq_reg[QW-1]};

    always_comb begin
        dq_next = dq_reg; drm_next = drm_reg; dcnt_next = dcnt_reg;
        dneg_next = dneg_reg; dbusy_next = dbusy_reg; ddone = 1'b0;
        if (cmd.op == OP_DIV) begin
            dq_next    = QW'(opa[W-1] ? W'(-opa) : opa) << FRAC_BITS;
            drm_next   = '0;
            dcnt_next  = CW'(QW);
            dneg_next  = opa[W-1];
            dbusy_next = 1'b1;
        end else if (dbusy_reg) begin
            if (dtry >= (W+2)'(b0mag)) begin
                drm_next = (W+1)'(dtry - (W+2)'(b0mag));
                dq_next  = {dq_reg[QW-2:0], 1'b1};
            end else begin
                drm_next = dtry[W:0];
                dq_next  = {dq_reg[QW-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - CW'(1);
            if (dcnt_reg == CW'(1)) begin
                dbusy_next = 1'b0;
                ddone      = 1'b1;
            end
        end
    end

    always_comb begin
        if (dneg_reg) dres = (dq_next >= QLIM) ? VMIN : W'(-dq_next);
        else          dres = (dq_next > QW'(VMAX)) ? VMAX : dq_next[W-1:0];
    end

    assign stat.busy = dbusy_reg;

    // ALU selection
    always_comb begin
        res = opa;
        wr  = 1'b1;
        case (cmd.op)
            OP_MUL:    res = mres;
            OP_ADD:    res = satw((W+2)'(opa) + (W+2)'(opb));
            OP_SUB:    res = satw((W+2)'(opa) - (W+2)'(opb));
            OP_NEG:    res = satw(-(W+2)'(opa));
            OP_TRIPLE: res = satw((W+2)'(opa) * (W+2)'(3));
            OP_DOUBLE: res = satw((W+2)'(opa) * (W+2)'(2));
            OP_VFLOOR: res = (opa < ONE) ? ONE : opa;
            OP_SCHED: begin
                res = opa;
                if (res < signed'(W'(cfg_smin))) res = signed'(W'(cfg_smin));
                if (res > signed'(W'(cfg_smax))) res = signed'(W'(cfg_smax));
            end
            OP_B0LIM: begin
                res = opa;
                if (res < W'(1)) res = W'(1);
                if (W > 31 && res > signed'(W'(32'h7FFF_FFFF)))
                    res = signed'(W'(32'h7FFF_FFFF));
            end
            default: wr = 1'b0;
        endcase
    end

    // scratch file and observer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z1_reg <= '0; z2_reg <= '0; z3_reg <= '0;
            dbusy_reg <= 1'b0;
        end else begin
            dbusy_reg <= dbusy_next;
            if (cmd.op == OP_COMMIT) begin
                z1_reg <= rf_reg[SL_T0];
                z2_reg <= rf_reg[SL_T1];
                if (rf_reg[SL_T2] > ZLIM)       z3_reg <= ZLIM;
                else if (rf_reg[SL_T2] < -ZLIM) z3_reg <= -ZLIM;
                else                            z3_reg <= rf_reg[SL_T2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg <= dq_next; drm_reg <= drm_next; dcnt_reg <= dcnt_next;
        dneg_reg <= dneg_next;
        if (load) begin
            rf_reg[SL_R]  <= sext(in_r);
            rf_reg[SL_Y]  <= sext(in_y);
            rf_reg[SL_V]  <= W'(in_v);
            rf_reg[SL_DT] <= W'(cfg_dt);
            rf_reg[SL_WC] <= W'(cfg_wc);
            rf_reg[SL_WO] <= W'(cfg_wo);
            rf_reg[SL_PG] <= W'(cfg_pg);
            rf_reg[SL_GR] <= W'(cfg_gr);
            rf_reg[SL_Z1] <= z1_reg;
            rf_reg[SL_Z2] <= z2_reg;
            rf_reg[SL_Z3] <= z3_reg;
        end else if (ddone) begin
            rf_reg[SL_T3] <= dres;
        end else if (wr) begin
            rf_reg[cmd.dst] <= res;
        end
    end

    // result fields
    logic signed [W-1:0] u_r;
    always_comb begin
        u_r = rf_reg[SL_T3];
        if (u_r > ONE)  u_r = ONE;
        if (u_r < -ONE) u_r = -ONE;
    end
    assign drive    = u_r[17:0];
    assign dist_est = z3_reg[22:0];
    assign gain     = rf_reg[SL_B0][30:0];

endmodule

>>> rtl/core/adrc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_controller: sequencer for one controller step
// Walks a fixed command program, waits on the divider, holds the result.
// ----------------------------------------------------------------------------
module adrc_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            load,
    output adrc_pkg::cmd_t  cmd,
    input  adrc_pkg::stat_t stat
);
    import adrc_pkg::*;

    localparam int PCW = $clog2(NUM_STEPS);

    state_t         state_reg, state_next;
    logic [PCW-1:0] pc_reg, pc_next;
    cmd_t           prog;

    // step program; T0..T3 are temporaries, B0 holds the gain
    always_comb begin
        prog = '{OP_NOP, SL_R, SL_R, SL_R};
        case (pc_reg)
            PCW'(0):  prog = '{OP_VFLOOR, SL_V,  SL_V,  SL_V};
            PCW'(1):  prog = '{OP_MUL,    SL_V,  SL_V,  SL_T0};
            PCW'(2):  prog = '{OP_MUL,    SL_T0, SL_PG, SL_T0};
            PCW'(3):  prog = '{OP_SCHED,  SL_T0, SL_T0, SL_T0};
            PCW'(4):  prog = '{OP_MUL,    SL_GR, SL_T0, SL_B0};
            PCW'(5):  prog = '{OP_B0LIM,  SL_B0, SL_B0, SL_B0};
            PCW'(6):  prog = '{OP_MUL,    SL_WO, SL_WO, SL_T0};  // wo2
            PCW'(7):  prog = '{OP_MUL,    SL_T0, SL_WO, SL_T1};  // b3
            PCW'(8):  prog = '{OP_TRIPLE, SL_T0, SL_T0, SL_T0};  // b2
            PCW'(9):  prog = '{OP_SUB,    SL_Z1, SL_Y,  SL_Y};   // e
            PCW'(10): prog = '{OP_MUL,    SL_T1, SL_Y,  SL_T1};  // b3*e
            PCW'(11): prog = '{OP_NEG,    SL_T1, SL_T1, SL_T1};
            PCW'(12): prog = '{OP_MUL,    SL_DT, SL_T1, SL_T1};
            PCW'(13): prog = '{OP_ADD,    SL_Z3, SL_T1, SL_T2};  // z3
            PCW'(14): prog = '{OP_MUL,    SL_T0, SL_Y,  SL_T0};  // b2*e
            PCW'(15): prog = '{OP_SUB,    SL_Z3, SL_T0, SL_T0};
            PCW'(16): prog = '{OP_MUL,    SL_DT, SL_T0, SL_T0};
            PCW'(17): prog = '{OP_ADD,    SL_Z2, SL_T0, SL_T1};  // z2
            PCW'(18): prog = '{OP_TRIPLE, SL_WO, SL_WO, SL_T0};  // b1
            PCW'(19): prog = '{OP_MUL,    SL_T0, SL_Y,  SL_T0};
            PCW'(20): prog = '{OP_SUB,    SL_Z2, SL_T0, SL_T0};
            PCW'(21): prog = '{OP_MUL,    SL_DT, SL_T0, SL_T0};
            PCW'(22): prog = '{OP_ADD,    SL_Z1, SL_T0, SL_T0};  // z1
            PCW'(23): prog = '{OP_SUB,    SL_R,  SL_T0, SL_R};   // er
            PCW'(24): prog = '{OP_MUL,    SL_WC, SL_WC, SL_Y};   // kp
            PCW'(25): prog = '{OP_MUL,    SL_Y,  SL_R,  SL_R};   // kp*er
            PCW'(26): prog = '{OP_DOUBLE, SL_WC, SL_WC, SL_Y};   // kd
            PCW'(27): prog = '{OP_MUL,    SL_Y,  SL_T1, SL_Y};   // kd*z2
            PCW'(28): prog = '{OP_SUB,    SL_R,  SL_Y,  SL_R};
            PCW'(29): prog = '{OP_SUB,    SL_R,  SL_T2, SL_R};
            PCW'(30): prog = '{OP_DIV,    SL_R,  SL_B0, SL_T3};  // u
            PCW'(31): prog = '{OP_MUL,    SL_B0, SL_T3, SL_Y};
            PCW'(32): prog = '{OP_MUL,    SL_DT, SL_Y,  SL_Y};
            default:  prog = '{OP_NOP,    SL_R,  SL_R,  SL_R};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // next state and command issue; z2 feedback add and commit at the tail
    logic [1:0] tail_reg, tail_next;
    always_ff @(posedge aclk) begin
        if (!aresetn) tail_reg <= '0;
        else          tail_reg <= tail_next;
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        tail_next  = tail_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        load       = 1'b0;
        cmd        = '{OP_NOP, SL_R, SL_R, SL_R};
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    load       = 1'b1;
                    pc_next    = '0;
                    tail_next  = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (pc_reg < PCW'(NUM_STEPS)) begin
                    cmd     = prog;
                    pc_next = pc_reg + PCW'(1);
                    if (prog.op == OP_DIV) state_next = ST_WAIT;
                end else if (tail_reg == 2'd0) begin
                    cmd       = '{OP_ADD, SL_T1, SL_Y, SL_T1};
                    tail_next = 2'd1;
                end else begin
                    cmd        = '{OP_COMMIT, SL_R, SL_R, SL_R};
                    state_next = ST_OUT;
                end
            end
            ST_WAIT: begin
                if (!stat.busy) state_next = ST_ISSUE;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/adrc_rate_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_rate_controller_core: one-axis linear ADRC rate controller
// Gain schedule, third-order observer and PD law on a shared datapath.
//
//  channel  dir  fields (low bit up)
//  s_       in   rate_setpoint[31:0], rate_measured[63:32], airspeed[88:64]
//  m_       out  drive[17:0], disturbance_est[40:18], scheduled_gain[71:41]
//  cfg_     in   index 0..6, data low bits
//
// The serial divider yields one quotient bit a cycle; the sequencer issues one
// command a cycle, pausing while the divider is busy.
// Reset is synchronous; no input beat is taken until the result is taken.
// ----------------------------------------------------------------------------
module adrc_rate_controller_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rate_setpoint, rate_measured, airspeed
    input  logic [95:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive, disturbance_est, scheduled_gain
    output logic [71:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adrc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import adrc_pkg::*;

    logic [16:0] dt_reg, pg_reg;
    logic [22:0] wc_reg, wo_reg, smin_reg, smax_reg;
    logic [24:0] gr_reg;
    logic        load;
    cmd_t        cmd;
    stat_t       stat;
    logic [17:0] drive;
    logic [22:0] dist_est;
    logic [30:0] gain;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= 17'd66; wc_reg <= 23'd1310720; wo_reg <= 23'd3932160;
            gr_reg <= 25'd655360; pg_reg <= 17'd66;
            smin_reg <= 23'd16384; smax_reg <= 23'd262144;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SAMPLE_PERIOD:  dt_reg   <= cfg_data[16:0];
                REG_CTRL_BANDWIDTH: wc_reg   <= cfg_data[22:0];
                REG_OBS_BANDWIDTH:  wo_reg   <= cfg_data[22:0];
                REG_GAIN_REFERENCE: gr_reg   <= cfg_data[24:0];
                REG_PRESSURE_GAIN:  pg_reg   <= cfg_data[16:0];
                REG_SCALE_MIN:      smin_reg <= cfg_data[22:0];
                REG_SCALE_MAX:      smax_reg <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    adrc_controller u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .load, .cmd, .stat
    );

    adrc_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .load,
        .in_r(s_tdata[31:0]), .in_y(s_tdata[63:32]), .in_v(s_tdata[88:64]),
        .cfg_dt(dt_reg), .cfg_wc(wc_reg), .cfg_wo(wo_reg), .cfg_gr(gr_reg),
        .cfg_pg(pg_reg), .cfg_smin(smin_reg), .cfg_smax(smax_reg),
        .cmd, .stat, .drive, .dist_est, .gain
    );

    assign m_tdata = {gain, dist_est, drive};

endmodule

>>> rtl/core/adrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_checker: port-level checks for the rate controller
// Bound to the top level; watches handshakes and result ranges.
// ----------------------------------------------------------------------------
module adrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    // one item at a time: no input taken while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during result");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    // scheduled gain never zero
    a_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:41] != 31'd0) else $error("zero gain");

    // an accepted input gives no result in the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("early result");
endmodule

bind adrc_rate_controller_core adrc_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for adrc_rate_controller_core
// Streams rate/airspeed beats through the controller across several register
// settings and handshake idling patterns, and checks every output beat
// against a cycle-free fixed-point model of the observer and control law.
// ----------------------------------------------------------------------------
module testbench;
    import adrc_pkg::*;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [24:0] airspeed;
        logic [31:0] rate_measured;
        logic [31:0] rate_setpoint;
    } rate_beat_t;

    typedef struct packed {
        logic [30:0] scheduled_gain;
        logic [22:0] disturbance_est;
        logic [17:0] drive;
    } ctrl_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    adrc_rate_controller_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // bench copy of registers and observer state
    longint dt_q, wc_q, wo_q, gref_q, pgain_q, smin_q, smax_q;
    longint obs_z1, obs_z2, obs_z3;

    rate_beat_t pending_beats[$];
    ctrl_beat_t expected_ctrl[$];
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int reg_writes = 0;
    int idle_cycles = 0;

    function automatic longint clip(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    // magnitude back to signed, limited to the 32-bit range
    function automatic longint signed_from_mag(logic [63:0] m, bit neg);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [127:0] prod;
        logic [63:0] ua, ub, m;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        if (prod[127:80] != 0) m = 64'h8000_0000;
        else m = prod[79:16];
        return signed_from_mag(m, (a < 0) != (b < 0));
    endfunction

    function automatic longint qdiv(longint num, longint den);
        logic [63:0] un, ud, q, rem, m;
        un = (num < 0) ? 64'(-num) : 64'(num);
        ud = 64'(den);
        q = un / ud;
        rem = un % ud;
        if (q > 64'(VMAX >>> 16)) m = 64'h8000_0000;
        else m = (q << 16) + ((rem << 16) / ud);
        return signed_from_mag(m, num < 0);
    endfunction

    function automatic void reset_controller_model();
        dt_q = 66; wc_q = 1310720; wo_q = 3932160; gref_q = 655360;
        pgain_q = 66; smin_q = 16384; smax_q = 262144;
        obs_z1 = 0; obs_z2 = 0; obs_z3 = 0;
    endfunction

    function automatic void load_reg(reg_idx_t idx, logic [31:0] val);
        case (idx)
            REG_SAMPLE_PERIOD:  dt_q    = longint'(val[16:0]);
            REG_CTRL_BANDWIDTH: wc_q    = longint'(val[22:0]);
            REG_OBS_BANDWIDTH:  wo_q    = longint'(val[22:0]);
            REG_GAIN_REFERENCE: gref_q  = longint'(val[24:0]);
            REG_PRESSURE_GAIN:  pgain_q = longint'(val[16:0]);
            REG_SCALE_MIN:      smin_q  = longint'(val[22:0]);
            REG_SCALE_MAX:      smax_q  = longint'(val[22:0]);
            default: ;
        endcase
    endfunction

    // one control step: schedule, observer update, PD law, commit
    function automatic ctrl_beat_t predict_step(rate_beat_t b);
        longint r, y, v, s, b0, wo2, g1, g2, g3, e, z1, z2, z3, er, kp, kd, u0, u;
        ctrl_beat_t res;
        r = longint'($signed(b.rate_setpoint));
        y = longint'($signed(b.rate_measured));
        v = longint'(b.airspeed);
        if (v < ONE_Q) v = ONE_Q;
        s = qmul(qmul(v, v), pgain_q);
        if (s < smin_q) s = smin_q;
        if (s > smax_q) s = smax_q;
        b0 = qmul(gref_q, s);
        if (b0 < 1) b0 = 1;
        if (b0 > VMAX) b0 = VMAX;

        wo2 = qmul(wo_q, wo_q);
        g1 = clip(3 * wo_q);
        g2 = clip(3 * wo2);
        g3 = qmul(wo2, wo_q);
        e = clip(obs_z1 - y);
        z1 = clip(obs_z1 + qmul(dt_q, clip(obs_z2 - qmul(g1, e))));
        z2 = clip(obs_z2 + qmul(dt_q, clip(obs_z3 - qmul(g2, e))));
        z3 = clip(obs_z3 + qmul(dt_q, clip(-qmul(g3, e))));

        er = clip(r - z1);
        kp = qmul(wc_q, wc_q);
        kd = clip(2 * wc_q);
        u0 = clip(qmul(kp, er) - qmul(kd, z2));
        u = qdiv(clip(u0 - z3), b0);
        // control injected back into the derivative estimate
        z2 = clip(z2 + qmul(dt_q, qmul(b0, u)));

        if (z3 > 50 * ONE_Q) z3 = 50 * ONE_Q;
        if (z3 < -50 * ONE_Q) z3 = -50 * ONE_Q;
        obs_z1 = z1; obs_z2 = z2; obs_z3 = z3;
        if (u > ONE_Q) u = ONE_Q;
        if (u < -ONE_Q) u = -ONE_Q;

        res.drive = u[17:0];
        res.disturbance_est = z3[22:0];
        res.scheduled_gain = b0[30:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_ctrl.push_back(predict_step(rate_beat_t'(s_tdata[88:0])));
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tdata <= {7'd0, pending_beats.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        ctrl_beat_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                beats_out++;
                if (expected_ctrl.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = expected_ctrl.pop_front();
                    if (got.drive != want.drive)
                        report_mismatch("drive", $signed(got.drive), $signed(want.drive));
                    if (got.disturbance_est != want.disturbance_est)
                        report_mismatch("disturbance_est", $signed(got.disturbance_est),
                                        $signed(want.disturbance_est));
                    if (got.scheduled_gain != want.scheduled_gain)
                        report_mismatch("scheduled_gain", got.scheduled_gain,
                                        want.scheduled_gain);
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d beats outstanding", expected_ctrl.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high across back-to-back writes; caller lowers it
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        load_reg(idx, val);
        reg_writes++;
    endtask

    task automatic load_settings(logic [31:0] dt, logic [31:0] wc, logic [31:0] wo,
                                 logic [31:0] gr, logic [31:0] pg, logic [31:0] smin,
                                 logic [31:0] smax);
        write_reg(REG_SAMPLE_PERIOD, dt);
        write_reg(REG_CTRL_BANDWIDTH, wc);
        write_reg(REG_OBS_BANDWIDTH, wo);
        write_reg(REG_GAIN_REFERENCE, gr);
        write_reg(REG_PRESSURE_GAIN, pg);
        write_reg(REG_SCALE_MIN, smin);
        write_reg(REG_SCALE_MAX, smax);
        cfg_valid <= 1'b0;
    endtask

    function automatic void queue_beat(logic [31:0] r, logic [31:0] y, logic [24:0] v);
        rate_beat_t b;
        b.rate_setpoint = r;
        b.rate_measured = y;
        b.airspeed = v;
        pending_beats.push_back(b);
    endfunction

    // mostly flight-like values, some full-range noise
    function automatic void queue_random_beats(int n);
        int rnd, meas;
        repeat (n) begin
            if ($urandom_range(99) < 80) begin
                rnd = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                meas = rnd + int'($urandom_range(0, 1 << 17)) - (1 << 16);
                queue_beat(rnd, meas, 25'($urandom_range(0, 40 << 16)));
            end else begin
                queue_beat($urandom, $urandom, 25'($urandom_range(0, 1 << 24)));
            end
        end
    endfunction

    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || expected_ctrl.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
        endcase
    endtask

    initial begin
        reset_controller_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, airspeed floor, large airspeeds
        queue_beat(32'h0, 32'h0, 25'd0);
        queue_beat(32'h7FFF_FFFF, 32'h8000_0000, 25'd0);
        queue_beat(32'h8000_0000, 32'h7FFF_FFFF, 25'h100_0000);
        queue_beat(32'hFFFF_FFFF, 32'h0000_0001, 25'd65535);
        queue_beat(32'h0001_0000, 32'h0, 25'd65536);
        queue_beat(32'hFFFF_0000, 32'h0, 25'd65537);
        queue_beat(32'h0000_8000, 32'hFFFF_8000, 25'd20 << 16);
        queue_beat(32'h5555_5555, 32'hAAAA_AAAA, 25'h0AA_AAAA);
        queue_beat(32'hAAAA_AAAA, 32'h5555_5555, 25'h155_5555);
        queue_beat(32'h0, 32'h0, 25'hFF_FFFF);
        queue_beat(32'h0, 32'h0032_0000, 25'd30 << 16);
        queue_beat(32'h0, 32'hFFCE_0000, 25'd30 << 16);
        queue_beat(32'h0002_0000, 32'h0001_0000, 25'd1);
        queue_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 25'h100_0000);
        queue_beat(32'h8000_0000, 32'h8000_0000, 25'd0);
        queue_beat(32'h0, 32'h0, 25'd12 << 16);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;
                // minimum gain, zero bandwidths, tiny step
                1: load_settings(1, 0, 0, 0, 0, 0, 0);
                // everything at its upper extreme
                2: load_settings(65536, 6553600, 6553600, 16777216, 65536, 4194304, 4194304);
                // zero period freezes the observer
                3: load_settings(0, 1310720, 3932160, 655360, 66, 16384, 262144);
                // crossed scale limits
                4: load_settings(66, 1310720, 3932160, 655360, 66, 262144, 16384);
                // all register bits set, masked to width
                5: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                6: load_settings($urandom_range(1, 65536), $urandom_range(0, 6553600),
                                 $urandom_range(0, 6553600), $urandom_range(0, 16777216),
                                 $urandom_range(0, 65536), $urandom_range(0, 4194304),
                                 $urandom_range(0, 4194304));
                default: load_settings(66, 1310720, 3932160, 655360, 66, 16384, 262144);
            endcase
            set_idling(phase);
            queue_random_beats(PHASE_ITEMS);
            drain();
        end

        $display("covered %0d input beats, %0d output beats, %0d register writes",
                 beats_in, beats_out, reg_writes);
        $display("settings: defaults, extremes, zero period, crossed limits; four idling modes");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/adrc_pkg.sv
rtl/core/adrc_datapath.sv
rtl/core/adrc_controller.sv
rtl/core/adrc_rate_controller_core.sv
rtl/core/adrc_checker.sv
tb/sv/testbench.sv
